[src/frms_pkg.sv]
package frms_pkg;

  localparam int unsigned SampleW           = 16;
  localparam int unsigned RmsW              = 16;
  localparam int unsigned CountOutW         = 13;
  localparam int unsigned MaxLenDefault     = 4096;
  localparam int unsigned SampleBitsDefault = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

[src/frms_if.sv]
interface frms_in_if;
  import frms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);

endinterface

interface frms_out_if;
  import frms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RmsW-1:0]      rms;
  logic [CountOutW-1:0] sample_count;
  logic                 overflow;

  modport source (output valid, output rms, output sample_count, output overflow,
                  input ready);
  modport sink (input valid, input rms, input sample_count, input overflow,
                output ready);

endinterface

[src/frms_ctrl.sv]
module frms_ctrl import frms_pkg::*; #(
  parameter int unsigned MAX_LEN     = MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SumW  = 2 * SAMPLE_BITS - 2 + CntW;
  localparam int unsigned StepW = $clog2(SumW);

  typedef enum logic [5:0] {
    S_ACCUM  = 6'b000001,
    S_FLUSH  = 6'b000010,
    S_DIV    = 6'b000100,
    S_SQINIT = 6'b001000,
    S_SQRT   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACCUM: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.div_init = 1'b1;
        step_d         = StepW'(SumW - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = S_SQINIT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_SQINIT: begin
        cmd_o.sqrt_init = 1'b1;
        step_d          = StepW'(SAMPLE_BITS - 1);
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == '0) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_ACCUM;
        end
      end
      default: begin
        state_d = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[src/frms_datapath.sv]
module frms_datapath import frms_pkg::*; #(
  parameter int unsigned MAX_LEN     = MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      out_ready_i,
  output status_t                   status_o,
  output logic                      out_valid_o,
  output logic [RmsW-1:0]           rms_o,
  output logic [CountOutW-1:0]      sample_count_o,
  output logic                      overflow_o
);

  localparam int unsigned SampW = SAMPLE_BITS;
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SqW   = 2 * SampW;
  localparam int unsigned SumW  = 2 * SampW - 2 + CntW;
  localparam int unsigned RootW = SampW;
  localparam int unsigned RadW  = 2 * RootW;

  logic [SampW-1:0] samp;
  logic [SampW-1:0] mag;

  logic [SqW-1:0]   sq_q, sq_d;
  logic             sq_vld_q, sq_vld_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;

  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW:0]    div_trial;
  logic             div_ge;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RootW+1:0] srem_q, srem_d;
  logic [RootW+1:0] sq_shift;
  logic [RootW+1:0] sq_trial;
  logic             sq_ge;

  logic                 out_vld_q, out_vld_d;
  logic [RmsW-1:0]      rms_q;
  logic [CountOutW-1:0] cnt_out_q;
  logic                 ovf_out_q;

  if (SampW <= SampleW) begin : g_narrow
    assign samp = sample_i[SampW-1:0];
  end else begin : g_wide
    assign samp = SampW'($unsigned(sample_i));
  end

  assign mag = samp[SampW-1] ? (~samp + 1'b1) : samp;

  assign div_trial = {rem_q, sum_q[SumW-1]};
  assign div_ge    = div_trial >= {1'b0, count_q};

  assign sq_shift = {srem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;

  always_comb begin
    sq_d      = sq_q;
    sq_vld_d  = 1'b0;
    sum_d     = sum_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    rem_d     = rem_q;
    rad_d     = rad_q;
    root_d    = root_q;
    srem_d    = srem_q;
    out_vld_d = out_vld_q && !out_ready_i;

    if (cmd_i.take) begin
      if (count_q < CntW'(MAX_LEN)) begin
        sq_d     = SqW'(mag) * SqW'(mag);
        sq_vld_d = 1'b1;
        count_d  = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (sq_vld_q) begin
      sum_d = sum_q + SumW'(sq_q);
    end

    if (cmd_i.div_init) begin
      rem_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = div_ge ? CntW'(div_trial - {1'b0, count_q}) : CntW'(div_trial);
      sum_d = {sum_q[SumW-2:0], div_ge};
    end

    if (cmd_i.sqrt_init) begin
      rad_d  = RadW'(sum_q);
      root_d = '0;
      srem_d = '0;
    end

    if (cmd_i.sqrt_step) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (sq_ge) begin
        srem_d = sq_shift - sq_trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        srem_d = sq_shift;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
    end

    if (cmd_i.finish) begin
      sum_d     = '0;
      count_d   = '0;
      ovf_d     = 1'b0;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      sq_vld_q  <= sq_vld_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
    if (cmd_i.finish) begin
      rms_q     <= RmsW'(root_q);
      cnt_out_q <= CountOutW'(count_q);
      ovf_out_q <= ovf_q;
    end
  end

  assign status_o.out_busy = out_vld_q;
  assign out_valid_o       = out_vld_q;
  assign rms_o             = rms_q;
  assign sample_count_o    = cnt_out_q;
  assign overflow_o        = ovf_out_q;

endmodule

[src/frame_rms_top.sv]
// Channel  Dir  Fields                          Word
// in_i     in   sample[15:0] signed, last       one sample of a frame
// out_o    out  rms[15:0], sample_count[12:0],  one result per frame
//               overflow
//
// Samples are taken one word per cycle while a frame accumulates.
// After the word marked last, the input stalls while the controller steps through
// its flush, divide, root-init, square-root and done states in that order.
// The divide and square-root states drive the restoring divider (one quotient bit
// a cycle) and the square root unit (one root bit a cycle) that follows it.
// The result sits in an output register, so the next frame accumulates while it
// waits; a further frame end waits only if that result has still not been taken.
// Reset clears the running sum, the count, the overflow flag and the output valid.
module frame_rms_top import frms_pkg::*; #(
  parameter int unsigned MAX_LEN     = MaxLenDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  frms_in_if.sink    in_i,
  frms_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  frms_ctrl #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  frms_datapath #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_i       (in_i.sample),
    .out_ready_i    (out_o.ready),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .rms_o          (out_o.rms),
    .sample_count_o (out_o.sample_count),
    .overflow_o     (out_o.overflow)
  );

  assign in_i.ready = in_ready;

  // A closing word stops intake until the result has been computed.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
    else $error("input ready right after a frame end");

  // A new result is only loaded into a free output register.
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !out_o.valid)
    else $error("result loaded over a pending result");

  // An overflowed frame always reports the saturated count.
  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.sample_count == CountOutW'(MAX_LEN)))
    else $error("overflow reported without a saturated count");

endmodule

[test/tb_frame_rms_top.sv]
module tb_frame_rms_top;
  import frms_pkg::*;

  localparam int unsigned MaxLen      = MaxLenDefault;
  localparam int unsigned LongLen     = 100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [RmsW-1:0]      rms;
    logic [CountOutW-1:0] sample_count;
    logic                 overflow;
  } rms_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  frms_in_if  in_if ();
  frms_out_if out_if ();

  frame_rms_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Running state of the frame as the block should see it.
  logic [42:0]          sq_sum;
  logic [CountOutW-1:0] frame_cnt;
  logic                 frame_ovf;

  rms_result_t rms_expect_q[$];
  int unsigned err_count    = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;

  function automatic logic [RmsW-1:0] floor_sqrt(input logic [42:0] x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 16; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= 64'(x)) root = trial;
    end
    return root[RmsW-1:0];
  endfunction

  function automatic void frame_acc_step(input logic signed [SampleW-1:0] s, input logic l);
    logic [SampleW-1:0] mag;
    rms_result_t        res;
    mag = s[SampleW-1] ? (~s + 16'd1) : s;
    if (frame_cnt < MaxLen) begin
      sq_sum    = sq_sum + 43'(mag) * 43'(mag);
      frame_cnt = frame_cnt + 1'b1;
    end else begin
      frame_ovf = 1'b1;
    end
    if (l) begin
      res.rms          = floor_sqrt(sq_sum / 43'(frame_cnt));
      res.sample_count = frame_cnt;
      res.overflow     = frame_ovf;
      rms_expect_q.push_back(res);
      sq_sum    = '0;
      frame_cnt = '0;
      frame_ovf = 1'b0;
    end
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    int unsigned mode;
    mode = $urandom_range(0, 19);
    if (mode < 10) return SampleW'($urandom);
    if (mode < 13) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    return SampleW'($signed($urandom_range(0, 510)) - 255);
  endfunction

  task automatic sender_gap();
    int unsigned n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 10);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_word(input logic signed [SampleW-1:0] s, input logic l);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    frame_acc_step(s, l);
    sender_gap();
  endtask

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_word(pick_sample(), i == len);
  endtask

  task automatic send_random_frames(input int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) len = $urandom_range(1, 8);
      else if (pick < 19) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      send_frame(len);
      sent += len;
    end
  endtask

  task automatic test_edge_samples();
    send_word(16'sh0000, 1'b1);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7fff, 1'b1);
    send_word(16'shffff, 1'b1);
    send_word(16'sh0001, 1'b1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'shffff, 1'b1);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b1);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh0003, 1'b0);
    send_word(16'sh0004, 1'b1);
  endtask

  // A long frame of the most negative sample gives the largest possible mean square.
  task automatic test_long_frames();
    for (int unsigned i = 1; i <= LongLen; i++) send_word(16'sh8000, i == LongLen);
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int unsigned i = 0; i < 8; i++) send_frame($urandom_range(1, 3));
  endtask

  task automatic test_random_frames();
    send_random_frames(320);
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    send_random_frames(100);
  endtask

  initial begin
    int unsigned drain;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.last   = 1'b0;
    sq_sum       = '0;
    frame_cnt    = '0;
    frame_ovf    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_samples();
    test_long_frames();
    test_backpressure();
    test_random_frames();
    test_quiet_tail();
    in_if.valid <= 1'b0;
    while (rms_expect_q.size() != 0) @(posedge clk_i);
    drain = DrainCycles;
    repeat (drain) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[frame_rms_top] OK");
    end else begin
      $display("[frame_rms_top] ERROR");
    end
    $finish;
  end

  task automatic check_result();
    rms_result_t exp_res;
    if (rms_expect_q.size() == 0) begin
      $error("result with no frame pending: rms %0d, count %0d, overflow %0d",
             out_if.rms, out_if.sample_count, out_if.overflow);
      err_count++;
      return;
    end
    exp_res = rms_expect_q.pop_front();
    if (out_if.rms !== exp_res.rms) begin
      $error("rms: expected %0d, got %0d", exp_res.rms, out_if.rms);
      err_count++;
    end
    if (out_if.sample_count !== exp_res.sample_count) begin
      $error("sample_count: expected %0d, got %0d", exp_res.sample_count,
             out_if.sample_count);
      err_count++;
    end
    if (out_if.overflow !== exp_res.overflow) begin
      $error("overflow: expected %0d, got %0d", exp_res.overflow, out_if.overflow);
      err_count++;
    end
  endtask

  // The receiver stalls in short random bursts and, once on request, holds off
  // long enough for the block to fill up and stall its input.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldCycles;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= StallLimit) begin
        $display("[frame_rms_top] ERROR");
        $finish;
      end
    end
  end

endmodule

[files.f]
src/frms_pkg.sv
src/frms_if.sv
src/frms_ctrl.sv
src/frms_datapath.sv
src/frame_rms_top.sv
test/tb_frame_rms_top.sv
